FILE: design/mqmm_pkg.sv
`default_nettype none
package mqmm_pkg;

  localparam int NUM_QUEUES_DEF = 8;
  localparam int MEM_DEPTH_DEF  = 1024;
  localparam int MSG_WIDTH_DEF  = 32;

  localparam int KIND_W   = 2;
  localparam int QID_W    = 3;
  localparam int MSGF_W   = 32;
  localparam int BASEF_W  = 10;
  localparam int SIZEF_W  = 11;
  localparam int STATUS_W = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_CREATE = 2'd0,
    KIND_POST   = 2'd1,
    KIND_ACCEPT = 2'd2,
    KIND_FLUSH  = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_INVALID  = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NO_BLOCK = 3'd4
  } status_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [QID_W-1:0]   queue_id;
    logic [MSGF_W-1:0]  message;
    logic [BASEF_W-1:0] region_base;
    logic [SIZEF_W-1:0] region_size;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [QID_W-1:0]    created_id;
    logic [MSGF_W-1:0]   message_out;
  } out_item_t;

endpackage
`default_nettype wire

FILE: design/multi_queue_message_manager_unit.sv
`default_nettype none
// Message queue manager: create, post, accept and flush on a pool of queue
// blocks over one shared message memory. One operation is accepted per cycle
// when the result side keeps up; each operation passes the block lookup,
// then the memory port, then the result queue. Operations and results
// keep their order; a two-entry result queue absorbs output stalls.
module multi_queue_message_manager_unit #(
  parameter int NUM_QUEUES = mqmm_pkg::NUM_QUEUES_DEF,
  parameter int MEM_DEPTH  = mqmm_pkg::MEM_DEPTH_DEF,
  parameter int MSG_WIDTH  = mqmm_pkg::MSG_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mqmm_pkg::in_item_t in_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output mqmm_pkg::out_item_t     out_data,
  output logic                    out_valid,
  input  wire logic               out_ready
);

  localparam int AW = $clog2(MEM_DEPTH);

  logic                 cmd_valid;
  logic                 cmd_ready;
  logic                 cmd_write;
  logic                 cmd_read;
  logic [AW-1:0]        cmd_addr;
  logic [MSG_WIDTH-1:0] cmd_data;
  logic [mqmm_pkg::STATUS_W-1:0] cmd_status;
  logic [mqmm_pkg::QID_W-1:0]    cmd_created;

  mqmm_front #(.NUM_QUEUES(NUM_QUEUES), .MEM_DEPTH(MEM_DEPTH),
               .MSG_WIDTH(MSG_WIDTH)) u_front (
    .clk, .rst, .item(in_data), .item_valid(in_valid), .item_ready(in_ready),
    .cmd_valid, .cmd_ready, .cmd_write, .cmd_read, .cmd_addr, .cmd_data,
    .cmd_status, .cmd_created
  );

  mqmm_back #(.MEM_DEPTH(MEM_DEPTH), .MSG_WIDTH(MSG_WIDTH)) u_back (
    .clk, .rst, .cmd_valid, .cmd_ready, .cmd_write, .cmd_read, .cmd_addr,
    .cmd_data, .cmd_status, .cmd_created, .result(out_data),
    .result_valid(out_valid), .result_ready(out_ready)
  );

endmodule
`default_nettype wire

FILE: design/mqmm_front.sv
`default_nettype none
// Classifies an item against the control blocks, updates the blocks and
// issues one memory command with its result fields to the queue.
module mqmm_front #(
  parameter int NUM_QUEUES = mqmm_pkg::NUM_QUEUES_DEF,
  parameter int MEM_DEPTH  = mqmm_pkg::MEM_DEPTH_DEF,
  parameter int MSG_WIDTH  = mqmm_pkg::MSG_WIDTH_DEF,
  localparam int AW = $clog2(MEM_DEPTH),
  localparam int SW = $clog2(MEM_DEPTH + 1),
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1,
  localparam int CW = $clog2(NUM_QUEUES + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mqmm_pkg::in_item_t item,
  input  wire logic               item_valid,
  output logic                    item_ready,
  output logic                    cmd_valid,
  input  wire logic               cmd_ready,
  output logic                    cmd_write,
  output logic                    cmd_read,
  output logic [AW-1:0]           cmd_addr,
  output logic [MSG_WIDTH-1:0]    cmd_data,
  output logic [mqmm_pkg::STATUS_W-1:0] cmd_status,
  output logic [mqmm_pkg::QID_W-1:0]    cmd_created
);

  logic [CW-1:0] in_use;
  logic [AW-1:0] qbase [NUM_QUEUES];
  logic [SW-1:0] qsize [NUM_QUEUES];
  logic [SW-1:0] inoff [NUM_QUEUES];
  logic [SW-1:0] outoff [NUM_QUEUES];
  logic [SW-1:0] count [NUM_QUEUES];

  logic               fire;
  logic               qid_ok;
  logic [QW-1:0]      q;
  logic [QW-1:0]      newq;
  logic [SW-1:0]      rsize;
  logic [SW-1:0]      in_inc;
  logic [SW-1:0]      out_inc;
  logic [SW:0]        addr_sum;
  logic [mqmm_pkg::STATUS_W-1:0] st;
  logic               do_wr;
  logic               do_rd;

  assign item_ready = cmd_ready;
  assign fire = item_valid && item_ready;
  assign q = QW'(item.queue_id);
  assign newq = QW'(in_use);
  assign qid_ok = 32'(item.queue_id) < 32'(in_use);
  assign in_inc = inoff[q] + SW'(1);
  assign out_inc = outoff[q] + SW'(1);

  always_comb begin
    if (32'(item.region_size) > 32'(MEM_DEPTH)) begin
      rsize = SW'(MEM_DEPTH);
    end else begin
      rsize = SW'(item.region_size);
    end
    st = mqmm_pkg::ST_OK;
    do_wr = 1'b0;
    do_rd = 1'b0;
    addr_sum = '0;
    case (mqmm_pkg::kind_t'(item.kind))
      mqmm_pkg::KIND_CREATE: begin
        if (32'(in_use) >= 32'(NUM_QUEUES)) st = mqmm_pkg::ST_NO_BLOCK;
      end
      mqmm_pkg::KIND_POST: begin
        if (!qid_ok) st = mqmm_pkg::ST_INVALID;
        else if (count[q] >= qsize[q]) st = mqmm_pkg::ST_FULL;
        else do_wr = 1'b1;
        addr_sum = (SW+1)'(qbase[q]) + (SW+1)'(inoff[q]);
      end
      mqmm_pkg::KIND_ACCEPT: begin
        if (!qid_ok) st = mqmm_pkg::ST_INVALID;
        else if (count[q] == '0) st = mqmm_pkg::ST_EMPTY;
        else do_rd = 1'b1;
        addr_sum = (SW+1)'(qbase[q]) + (SW+1)'(outoff[q]);
      end
      mqmm_pkg::KIND_FLUSH: begin
        if (!qid_ok) st = mqmm_pkg::ST_INVALID;
      end
      default: st = mqmm_pkg::ST_INVALID;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
    end else if (fire && item.kind == mqmm_pkg::KIND_CREATE &&
                 st == mqmm_pkg::ST_OK) begin
      in_use <= in_use + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (item.kind == mqmm_pkg::KIND_CREATE && st == mqmm_pkg::ST_OK) begin
        qbase[newq]  <= AW'(item.region_base);
        qsize[newq]  <= rsize;
        inoff[newq]  <= '0;
        outoff[newq] <= '0;
        count[newq]  <= '0;
      end else if (item.kind == mqmm_pkg::KIND_FLUSH && st == mqmm_pkg::ST_OK) begin
        inoff[q]  <= '0;
        outoff[q] <= '0;
        count[q]  <= '0;
      end else if (do_wr) begin
        count[q] <= count[q] + SW'(1);
        inoff[q] <= (in_inc >= qsize[q]) ? '0 : in_inc;
      end else if (do_rd) begin
        count[q]  <= count[q] - SW'(1);
        outoff[q] <= (out_inc >= qsize[q]) ? '0 : out_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (cmd_ready) begin
      cmd_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      cmd_write   <= do_wr;
      cmd_read    <= do_rd;
      cmd_addr    <= (addr_sum >= (SW+1)'(MEM_DEPTH)) ?
                     AW'(addr_sum - (SW+1)'(MEM_DEPTH)) : AW'(addr_sum);
      cmd_data    <= MSG_WIDTH'(item.message);
      cmd_status  <= st;
      cmd_created <= (item.kind == mqmm_pkg::KIND_CREATE && st == mqmm_pkg::ST_OK) ?
                     mqmm_pkg::QID_W'(in_use) : '0;
    end
  end

  a_inuse_bound: assert property (@(posedge clk) disable iff (rst)
    32'(in_use) <= 32'(NUM_QUEUES))
    else $error("block count beyond pool");
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    !(do_wr && do_rd))
    else $error("write and read together");
  a_create_grows: assert property (@(posedge clk) disable iff (rst)
    fire && item.kind == mqmm_pkg::KIND_CREATE && st == mqmm_pkg::ST_OK
    |=> in_use == $past(in_use) + CW'(1))
    else $error("create did not take a block");

endmodule
`default_nettype wire

FILE: design/mqmm_back.sv
`default_nettype none
// Carries out memory commands and holds the result in a two-entry skid queue.
module mqmm_back #(
  parameter int MEM_DEPTH = mqmm_pkg::MEM_DEPTH_DEF,
  parameter int MSG_WIDTH = mqmm_pkg::MSG_WIDTH_DEF,
  localparam int AW = $clog2(MEM_DEPTH)
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cmd_valid,
  output logic                 cmd_ready,
  input  wire logic            cmd_write,
  input  wire logic            cmd_read,
  input  wire logic [AW-1:0]   cmd_addr,
  input  wire logic [MSG_WIDTH-1:0] cmd_data,
  input  wire logic [mqmm_pkg::STATUS_W-1:0] cmd_status,
  input  wire logic [mqmm_pkg::QID_W-1:0]    cmd_created,
  output mqmm_pkg::out_item_t  result,
  output logic                 result_valid,
  input  wire logic            result_ready
);

  logic [MSG_WIDTH-1:0] mem [MEM_DEPTH];
  logic [MSG_WIDTH-1:0] rdata;

  logic                 s1_valid;
  logic                 s1_read;
  logic [mqmm_pkg::STATUS_W-1:0] s1_status;
  logic [mqmm_pkg::QID_W-1:0]    s1_created;

  mqmm_pkg::out_item_t  s1_item;
  mqmm_pkg::out_item_t  buf_item [2];
  logic [1:0]           used;
  logic                 wptr;
  logic                 rptr;
  logic                 take;
  logic                 pop;
  logic                 push;

  // Space for the item in memory read plus one in flight.
  assign take = cmd_valid && cmd_ready;
  assign cmd_ready = (used == 2'd0) || (used == 2'd1 && (!s1_valid || pop)) ||
                     (used == 2'd2 && !s1_valid && pop);
  assign pop = result_valid && result_ready;
  assign push = s1_valid;

  always_ff @(posedge clk) begin
    if (take && cmd_write) mem[cmd_addr] <= cmd_data;
    if (take && cmd_read) rdata <= mem[cmd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else s1_valid <= take;
    if (take) begin
      s1_read    <= cmd_read;
      s1_status  <= cmd_status;
      s1_created <= cmd_created;
    end
  end

  always_comb begin
    s1_item.status      = s1_status;
    s1_item.created_id  = s1_created;
    s1_item.message_out = s1_read ? mqmm_pkg::MSGF_W'(rdata) : '0;
  end

  always_ff @(posedge clk) begin
    if (push) buf_item[wptr] <= s1_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      wptr <= 1'b0;
      rptr <= 1'b0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop) rptr <= !rptr;
      used <= used + 2'(push) - 2'(pop);
    end
  end

  assign result_valid = used != 2'd0;
  assign result = buf_item[rptr];

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(used == 2'd2 && push && !pop))
    else $error("result queue overflow");
  a_rw_excl: assert property (@(posedge clk) disable iff (rst)
    take |-> !(cmd_write && cmd_read))
    else $error("write and read together");
  a_space: assert property (@(posedge clk) disable iff (rst)
    take |=> (used != 2'd2) || pop)
    else $error("took command without space");

endmodule
`default_nettype wire
